// ----- hdl/assert_macros.svh -----
// assertion helpers used by the decompressor unit
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH
`ifndef SYNTHESIS
`define LZ_ASSERT(lbl, clk, rstn, prop) \
  lbl: assert property (@(posedge clk) disable iff (!rstn) prop) \
    else $error("assertion failed");
`define LZ_ASSERT_ALWAYS(lbl, clk, prop) \
  lbl: assert property (@(posedge clk) prop) else $error("assertion failed");
`else
`define LZ_ASSERT(lbl, clk, rstn, prop)
`define LZ_ASSERT_ALWAYS(lbl, clk, prop)
`endif
`endif

// ----- hdl/lzmd_pkg.sv -----
// ----------------------------------------------------------------------------
// lzmd_pkg
// types and constants of the multi mode lz decompressor
// ----------------------------------------------------------------------------
package lzmd_pkg;

  localparam int AW           = 16;
  localparam int WINDOW_BYTES = 1 << AW;

  localparam logic [1:0] ST_OK      = 2'd0;
  localparam logic [1:0] ST_UNKNOWN = 2'd1;
  localparam logic [1:0] ST_OVF     = 2'd2;

  localparam logic [15:0] MODE_ABS    = 16'd0;
  localparam logic [15:0] MODE_TOK10  = 16'd2;
  localparam logic [15:0] MODE_TOK11  = 16'd4;
  localparam logic [15:0] MODE_FLAG11 = 16'd6;
  localparam logic [15:0] MODE_FLAG12 = 16'd8;
  localparam logic [15:0] MODE_STORED = 16'd10;

  typedef struct packed {
    logic [7:0] in_byte;
    logic       start_of_stream;
  } in_word_t;

  typedef struct packed {
    logic [7:0]  out_byte_first;
    logic [7:0]  out_byte_second;
    logic [1:0]  byte_count;
    logic        run_last;
    logic        stream_done;
    logic [15:0] produced_length;
    logic [1:0]  status;
  } out_word_t;

  typedef enum logic [14:0] {
    PH_HDR0   = 15'h0001,
    PH_HDR1   = 15'h0002,
    PH_HDR2   = 15'h0004,
    PH_HDR3   = 15'h0008,
    PH_TOKEN  = 15'h0010,
    PH_LIT    = 15'h0020,
    PH_OFS0   = 15'h0040,
    PH_OFS1   = 15'h0080,
    PH_DIST   = 15'h0100,
    PH_FLAG   = 15'h0200,
    PH_COUNT  = 15'h0400,
    PH_MB1    = 15'h0800,
    PH_MB2    = 15'h1000,
    PH_STORED = 15'h2000,
    PH_DONE   = 15'h4000
  } phase_t;

  typedef enum logic [2:0] {
    SQ_IDLE = 3'b001,
    SQ_RD   = 3'b010,
    SQ_WR   = 3'b100
  } seq_t;

endpackage

// ----- hdl/lzmd_ram.sv -----
// ----------------------------------------------------------------------------
// lzmd_ram
// generic single write, single read ram with registered read data
// ----------------------------------------------------------------------------
module lzmd_ram #(
  parameter int W     = 8,
  parameter int DEPTH = 256
) (
  input  logic                     clk,
  input  logic                     we,
  input  logic [$clog2(DEPTH)-1:0] waddr,
  input  logic [W-1:0]             wdata,
  input  logic                     re,
  input  logic [$clog2(DEPTH)-1:0] raddr,
  output logic [W-1:0]             rdata
);

  logic [W-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    if (re) begin
      rdata <= mem[raddr];
    end
  end

endmodule

// ----- hdl/lz_multi_mode_decompressor_unit.sv -----
// ----------------------------------------------------------------------------
// lz_multi_mode_decompressor_unit
// byte serial lz77 style decompressor with six stream formats
// ----------------------------------------------------------------------------
// Header, token, literal and stored bytes each finish in the cycle they are
// accepted; input stalls while a result word is held. A match of n bytes runs
// through the single port pair of the history ram, a read state then a write
// state per byte, the write waiting on a held output; no byte is accepted until
// it ends. Match words pair up to two bytes, literal and stored words carry one.
// The history needs no clearing pass after reset.
`include "assert_macros.svh"

module lz_multi_mode_decompressor_unit import lzmd_pkg::*; (
  input  logic      clk,
  input  logic      rst_n,
  input  logic      in_valid,
  output logic      in_stall,
  input  in_word_t  in_data,
  output logic      out_valid,
  input  logic      out_stall,
  output out_word_t out_data,
  input  logic      cfg_valid,
  output logic      cfg_ready,
  input  logic      cfg_data
);

  phase_t            phase_r, phase_nxt;
  seq_t              seq_r, seq_nxt;
  logic [3:0]        mode_r, mode_nxt;
  logic [15:0]       hsize_r, hsize_nxt;
  logic [7:0]        tok_r, tok_nxt;
  logic [7:0]        fbits_r, fbits_nxt;
  logic [3:0]        fleft_r, fleft_nxt;
  logic [7:0]        pend_r, pend_nxt;
  logic [15:0]       lit_r, lit_nxt;
  logic [16:0]       pos_r, pos_nxt;
  logic [AW-1:0]     wr_r, wr_nxt;
  logic [AW-1:0]     src_r, src_nxt;
  logic [7:0]        cnt_r, cnt_nxt;
  logic              half_r, half_nxt;
  logic [7:0]        first_r, first_nxt;
  logic              be_r, be_nxt;
  logic              out_valid_r, out_valid_nxt;
  out_word_t         out_r, out_nxt;

  logic              ram_we, ram_re;
  logic [AW-1:0]     ram_wa, ram_ra;
  logic [7:0]        ram_wd, ram_rd;

  logic              in_fire, out_free;

  function automatic logic [15:0] word16(logic [7:0] a, logic [7:0] b, logic be);
    return be ? {a, b} : {b, a};
  endfunction

  function automatic logic [16:0] sat_inc(logic [16:0] p);
    return (p < 17'h10000) ? p + 17'd1 : p;
  endfunction

  function automatic phase_t next_flag(logic [3:0] fl, logic [7:0] fb);
    if (fl == 4'd0) begin
      return PH_FLAG;
    end
    return fb[0] ? PH_MB1 : PH_COUNT;
  endfunction

  lzmd_ram #(.W(8), .DEPTH(WINDOW_BYTES)) u_hist (
    .clk   (clk),
    .we    (ram_we),
    .waddr (ram_wa),
    .wdata (ram_wd),
    .re    (ram_re),
    .raddr (ram_ra),
    .rdata (ram_rd)
  );

  assign in_stall  = (seq_r != SQ_IDLE) || (out_valid_r && out_stall);
  assign in_fire   = in_valid && !in_stall;
  assign out_free  = !out_valid_r || !out_stall;
  assign out_valid = out_valid_r;
  assign out_data  = out_r;
  assign cfg_ready = 1'b1;

  always_comb begin
    logic [7:0]  b;
    logic [15:0] w;
    logic [6:0]  len;
    logic [11:0] d;
    logic        done, emit, last, need;
    logic [1:0]  st;
    logic [3:0]  fl;
    logic [7:0]  fb;

    phase_nxt     = phase_r;
    seq_nxt       = seq_r;
    mode_nxt      = mode_r;
    hsize_nxt     = hsize_r;
    tok_nxt       = tok_r;
    fbits_nxt     = fbits_r;
    fleft_nxt     = fleft_r;
    pend_nxt      = pend_r;
    lit_nxt       = lit_r;
    pos_nxt       = pos_r;
    wr_nxt        = wr_r;
    src_nxt       = src_r;
    cnt_nxt       = cnt_r;
    half_nxt      = half_r;
    first_nxt     = first_r;
    be_nxt        = cfg_valid ? cfg_data : be_r;
    out_valid_nxt = out_valid_r && out_stall;
    out_nxt       = out_r;
    ram_we        = 1'b0;
    ram_re        = 1'b0;
    ram_wa        = wr_r;
    ram_ra        = src_r;
    ram_wd        = in_data.in_byte;
    b             = in_data.in_byte;
    w             = word16(pend_r, b, be_r);
    len           = '0;
    d             = '0;
    done          = 1'b0;
    emit          = 1'b0;
    last          = 1'b0;
    need          = 1'b0;
    st            = ST_OK;
    fl            = (fleft_r != 4'd0) ? fleft_r - 4'd1 : 4'd0;
    fb            = {1'b0, fbits_r[7:1]};

    unique case (seq_r)
      SQ_IDLE: begin
        if (in_fire) begin
          if (in_data.start_of_stream) begin
            pos_nxt   = '0;
            wr_nxt    = '0;
            pend_nxt  = b;
            phase_nxt = PH_HDR1;
          end else begin
            unique case (phase_r)
              PH_HDR0: begin
                pend_nxt  = b;
                phase_nxt = PH_HDR1;
              end
              PH_HDR1: begin
                hsize_nxt = w;
                phase_nxt = PH_HDR2;
              end
              PH_HDR2: begin
                pend_nxt  = b;
                phase_nxt = PH_HDR3;
              end
              PH_HDR3: begin
                pos_nxt  = '0;
                wr_nxt   = '0;
                mode_nxt = w[3:0];
                if (w == MODE_ABS || w == MODE_TOK10 || w == MODE_TOK11) begin
                  phase_nxt = PH_TOKEN;
                end else if (w == MODE_FLAG11 || w == MODE_FLAG12) begin
                  fleft_nxt = '0;
                  phase_nxt = PH_FLAG;
                end else if (w == MODE_STORED) begin
                  lit_nxt   = hsize_r;
                  phase_nxt = PH_STORED;
                  if (hsize_r == 16'd0) begin
                    done      = 1'b1;
                    phase_nxt = PH_DONE;
                  end
                end else begin
                  st        = ST_UNKNOWN;
                  done      = 1'b1;
                  phase_nxt = PH_DONE;
                end
              end
              PH_TOKEN: begin
                tok_nxt = b;
                if (!b[7]) begin
                  lit_nxt   = {9'd0, b[6:0]} + 16'd1;
                  phase_nxt = PH_LIT;
                end else begin
                  if (mode_r == MODE_ABS[3:0]) begin
                    len = b[6:0];
                  end else if (mode_r == MODE_TOK10[3:0]) begin
                    len = {2'b0, b[6:2]};
                  end else begin
                    len = {3'b0, b[6:3]};
                  end
                  if (len == 7'd0) begin
                    done      = 1'b1;
                    phase_nxt = PH_DONE;
                  end else begin
                    phase_nxt = (mode_r == MODE_ABS[3:0]) ? PH_OFS0 : PH_DIST;
                  end
                end
              end
              PH_LIT: begin
                emit = 1'b1;
                if (lit_r != 16'd0) begin
                  lit_nxt = lit_r - 16'd1;
                end
                if (lit_r <= 16'd1) begin
                  if (mode_r == MODE_FLAG11[3:0] || mode_r == MODE_FLAG12[3:0]) begin
                    fbits_nxt = fb;
                    fleft_nxt = fl;
                    phase_nxt = next_flag(fl, fb);
                  end else begin
                    phase_nxt = PH_TOKEN;
                  end
                end
              end
              PH_OFS0: begin
                pend_nxt  = b;
                phase_nxt = PH_OFS1;
              end
              PH_OFS1: begin
                src_nxt   = w[AW-1:0];
                cnt_nxt   = {1'b0, tok_r[6:0]} + 8'd1;
                seq_nxt   = SQ_RD;
                half_nxt  = 1'b0;
                phase_nxt = PH_TOKEN;
              end
              PH_DIST: begin
                if (mode_r == MODE_TOK10[3:0]) begin
                  d       = {2'b0, tok_r[1:0], b};
                  cnt_nxt = {3'b0, tok_r[6:2]} + 8'd1;
                end else begin
                  d       = {1'b0, tok_r[2:0], b};
                  cnt_nxt = {4'b0, tok_r[6:3]} + 8'd1;
                end
                src_nxt   = wr_r - {{(AW-12){1'b0}}, d};
                seq_nxt   = SQ_RD;
                half_nxt  = 1'b0;
                phase_nxt = PH_TOKEN;
              end
              PH_FLAG: begin
                fbits_nxt = b;
                fleft_nxt = 4'd8;
                phase_nxt = b[0] ? PH_MB1 : PH_COUNT;
              end
              PH_COUNT: begin
                if (b == 8'd0) begin
                  done      = 1'b1;
                  phase_nxt = PH_DONE;
                end else begin
                  lit_nxt   = {8'd0, b};
                  phase_nxt = PH_LIT;
                end
              end
              PH_MB1: begin
                tok_nxt   = b;
                phase_nxt = PH_MB2;
              end
              PH_MB2: begin
                if (mode_r == MODE_FLAG11[3:0]) begin
                  d       = {1'b0, tok_r[2:0], b};
                  cnt_nxt = {3'b0, tok_r[7:3]} + 8'd3;
                end else begin
                  d       = {tok_r[3:0], b};
                  cnt_nxt = {4'b0, tok_r[7:4]} + 8'd3;
                end
                src_nxt   = wr_r - {{(AW-12){1'b0}}, d};
                seq_nxt   = SQ_RD;
                half_nxt  = 1'b0;
                fbits_nxt = fb;
                fleft_nxt = fl;
                phase_nxt = next_flag(fl, fb);
              end
              PH_STORED: begin
                emit = 1'b1;
                if (lit_r != 16'd0) begin
                  lit_nxt = lit_r - 16'd1;
                end
                if (lit_r <= 16'd1) begin
                  done      = 1'b1;
                  phase_nxt = PH_DONE;
                end
              end
              default: begin
                phase_nxt = PH_DONE;
              end
            endcase
          end
          if (emit) begin
            ram_we  = 1'b1;
            wr_nxt  = wr_r + AW'(1);
            pos_nxt = sat_inc(pos_r);
          end
          if (emit || done) begin
            out_valid_nxt                 = 1'b1;
            out_nxt                       = '0;
            out_nxt.out_byte_first        = emit ? b : 8'd0;
            out_nxt.byte_count            = emit ? 2'd1 : 2'd0;
            out_nxt.run_last              = 1'b1;
            if (done) begin
              out_nxt.stream_done     = 1'b1;
              out_nxt.produced_length = pos_nxt[16] ? 16'hffff : pos_nxt[15:0];
              out_nxt.status          = (st != ST_OK) ? st :
                                        (pos_nxt[16] ? ST_OVF : ST_OK);
            end
          end
        end
      end
      SQ_RD: begin
        ram_re  = 1'b1;
        src_nxt = src_r + AW'(1);
        seq_nxt = SQ_WR;
      end
      SQ_WR: begin
        last = (cnt_r == 8'd1);
        need = half_r || last;
        if (!need || out_free) begin
          ram_we    = 1'b1;
          ram_wd    = ram_rd;
          wr_nxt    = wr_r + AW'(1);
          pos_nxt   = sat_inc(pos_r);
          cnt_nxt   = cnt_r - 8'd1;
          half_nxt  = !need;
          first_nxt = ram_rd;
          seq_nxt   = last ? SQ_IDLE : SQ_RD;
          if (need) begin
            out_valid_nxt          = 1'b1;
            out_nxt                = '0;
            out_nxt.out_byte_first  = half_r ? first_r : ram_rd;
            out_nxt.out_byte_second = half_r ? ram_rd : 8'd0;
            out_nxt.byte_count      = half_r ? 2'd2 : 2'd1;
            out_nxt.run_last        = last;
          end
        end
      end
      default: begin
        seq_nxt = SQ_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      phase_r     <= PH_HDR0;
      seq_r       <= SQ_IDLE;
      mode_r      <= '0;
      hsize_r     <= '0;
      tok_r       <= '0;
      fbits_r     <= '0;
      fleft_r     <= '0;
      pend_r      <= '0;
      lit_r       <= '0;
      pos_r       <= '0;
      wr_r        <= '0;
      cnt_r       <= '0;
      half_r      <= 1'b0;
      be_r        <= 1'b1;
      out_valid_r <= 1'b0;
    end else begin
      phase_r     <= phase_nxt;
      seq_r       <= seq_nxt;
      mode_r      <= mode_nxt;
      hsize_r     <= hsize_nxt;
      tok_r       <= tok_nxt;
      fbits_r     <= fbits_nxt;
      fleft_r     <= fleft_nxt;
      pend_r      <= pend_nxt;
      lit_r       <= lit_nxt;
      pos_r       <= pos_nxt;
      wr_r        <= wr_nxt;
      cnt_r       <= cnt_nxt;
      half_r      <= half_nxt;
      be_r        <= be_nxt;
      out_valid_r <= out_valid_nxt;
    end
  end

  always_ff @(posedge clk) begin
    src_r   <= src_nxt;
    first_r <= first_nxt;
    out_r   <= out_nxt;
  end

  `LZ_ASSERT(a_half_clear_idle, clk, rst_n, (seq_r == SQ_IDLE) |-> !half_r)
  `LZ_ASSERT(a_copy_count_live, clk, rst_n, (seq_r != SQ_IDLE) |-> (cnt_r != 8'd0))
  `LZ_ASSERT(a_read_then_write, clk, rst_n, (seq_r == SQ_RD) |=> (seq_r == SQ_WR))
  `LZ_ASSERT(a_held_result, clk, rst_n, (out_valid_r && out_stall) |=> (out_valid_r && $stable(out_r)))

endmodule
